// ----- rtl/smt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smt_pkg
// Shared operation codes and controller states for the sorted multiset table.
// ----------------------------------------------------------------------------
package smt_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_DECIDE,
    S_SHIFT,
    S_PLACE,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/sorted_multiset_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_multiset_table
// Multiset of signed values held as an ascending table of distinct values,
// each with a count, in one synchronous memory.
// ----------------------------------------------------------------------------
// One item is worked on at a time. Every item starts with a lower-bound binary
// search of the used entries, each probe a read through the single memory
// read port and then a compare, then one more read of the found position. An
// insert of a new value moves every later entry up one place and a remove that
// takes a count to zero moves them down, at one entry per cycle through the
// memory read and write ports. The result sits in an output register, so the
// next item is taken as soon as the previous one has moved there. No clearing
// pass is needed after reset: only entries below the used count are ever used.
module sorted_multiset_table #(
  parameter int CAPACITY    = 2048,
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     op,
  input  wire logic signed [VALUE_WIDTH-1:0]  value,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                was_present,
  output logic [COUNT_WIDTH-1:0]              multiplicity,
  output logic [$clog2(CAPACITY+1)-1:0]       distinct_entries,
  output logic                                rejected
);
  import smt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = VALUE_WIDTH + COUNT_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  // table memory: value in the upper field, count in the lower
  logic [DW-1:0] mem [CAPACITY];
  logic [DW-1:0] rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;

  state_t                   state, state_next;
  logic [1:0]               op_r, op_r_next;
  logic [VALUE_WIDTH-1:0]   val_r, val_r_next;
  logic [CW-1:0]            lo, lo_next;
  logic [CW-1:0]            hi, hi_next;
  logic [CW-1:0]            used, used_next;
  logic [CW-1:0]            pos, pos_next;
  logic                     probe_ok, probe_ok_next;
  logic                     found_r, found_r_next;
  logic [COUNT_WIDTH-1:0]   cnt_r, cnt_r_next;
  logic                     rej_r, rej_r_next;
  logic [CW-1:0]            mv_left, mv_left_next;
  logic [AW-1:0]            rd_ptr, rd_ptr_next;
  logic                     sh_valid, sh_valid_next;
  logic [AW-1:0]            sh_addr, sh_addr_next;
  logic                     shift_up, shift_up_next;
  logic                     out_load;

  logic [CW-1:0]            mid;
  logic [VALUE_WIDTH-1:0]   rd_value;
  logic [COUNT_WIDTH-1:0]   rd_count;
  logic                     hit;
  logic [COUNT_WIDTH-1:0]   cur_cnt;

  assign rd_value = rdata[DW-1:COUNT_WIDTH];
  assign rd_count = rdata[COUNT_WIDTH-1:0];
  assign mid      = lo + ((hi - lo) >> 1);
  assign hit      = probe_ok && (rd_value == val_r);
  assign cur_cnt  = hit ? rd_count : '0;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_comb begin
    state_next    = state;
    op_r_next     = op_r;
    val_r_next    = val_r;
    lo_next       = lo;
    hi_next       = hi;
    used_next     = used;
    pos_next      = pos;
    probe_ok_next = probe_ok;
    found_r_next  = found_r;
    cnt_r_next    = cnt_r;
    rej_r_next    = rej_r;
    mv_left_next  = mv_left;
    rd_ptr_next   = rd_ptr;
    sh_valid_next = sh_valid;
    sh_addr_next  = sh_addr;
    shift_up_next = shift_up;
    mem_we        = 1'b0;
    mem_waddr     = pos[AW-1:0];
    mem_wdata     = {val_r, cnt_r};
    mem_raddr     = mid[AW-1:0];
    out_load      = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_r_next  = op;
          val_r_next = value;
          lo_next    = '0;
          hi_next    = used;
          rej_r_next = 1'b0;
          state_next = S_SEARCH;
        end
      end

      S_SEARCH: begin
        if (lo < hi) begin
          mem_raddr  = mid[AW-1:0];
          state_next = S_CMP;
        end else begin
          mem_raddr     = lo[AW-1:0];
          pos_next      = lo;
          probe_ok_next = (lo < used);
          state_next    = S_DECIDE;
        end
      end

      S_CMP: begin
        if ($signed(rd_value) < $signed(val_r)) begin
          lo_next = mid + CW'(1);
        end else begin
          hi_next = mid;
        end
        state_next = S_SEARCH;
      end

      S_DECIDE: begin
        found_r_next  = hit;
        cnt_r_next    = cur_cnt;
        sh_valid_next = 1'b0;
        state_next    = S_DONE;
        case (op_r)
          OP_INSERT: begin
            if (hit) begin
              if (cur_cnt == CNT_MAX) begin
                rej_r_next = 1'b1;
              end else begin
                cnt_r_next = cur_cnt + COUNT_WIDTH'(1);
                mem_we     = 1'b1;
                mem_waddr  = pos[AW-1:0];
                mem_wdata  = {val_r, cur_cnt + COUNT_WIDTH'(1)};
              end
            end else if (used == CAP) begin
              rej_r_next = 1'b1;
            end else begin
              cnt_r_next    = COUNT_WIDTH'(1);
              mv_left_next  = used - pos;
              rd_ptr_next   = AW'(used - CW'(1));
              shift_up_next = 1'b1;
              state_next    = S_SHIFT;
            end
          end
          OP_REMOVE: begin
            if (hit) begin
              cnt_r_next = cur_cnt - COUNT_WIDTH'(1);
              if (cur_cnt == COUNT_WIDTH'(1)) begin
                mv_left_next  = used - pos - CW'(1);
                rd_ptr_next   = AW'(pos + CW'(1));
                shift_up_next = 1'b0;
                state_next    = S_SHIFT;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = pos[AW-1:0];
                mem_wdata = {val_r, cur_cnt - COUNT_WIDTH'(1)};
              end
            end
          end
          default: begin
          end
        endcase
      end

      S_SHIFT: begin
        if (sh_valid) begin
          mem_we    = 1'b1;
          mem_waddr = shift_up ? sh_addr + AW'(1) : sh_addr - AW'(1);
          mem_wdata = rdata;
        end
        if (mv_left != '0) begin
          mem_raddr     = rd_ptr;
          sh_addr_next  = rd_ptr;
          sh_valid_next = 1'b1;
          rd_ptr_next   = shift_up ? rd_ptr - AW'(1) : rd_ptr + AW'(1);
          mv_left_next  = mv_left - CW'(1);
        end else begin
          sh_valid_next = 1'b0;
          if (!sh_valid) begin
            if (shift_up) begin
              state_next = S_PLACE;
            end else begin
              used_next  = used - CW'(1);
              state_next = S_DONE;
            end
          end
        end
      end

      S_PLACE: begin
        mem_we     = 1'b1;
        mem_waddr  = pos[AW-1:0];
        mem_wdata  = {val_r, COUNT_WIDTH'(1)};
        used_next  = used + CW'(1);
        state_next = S_DONE;
      end

      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
    end else begin
      state <= state_next;
      used  <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_r_next;
    val_r    <= val_r_next;
    lo       <= lo_next;
    hi       <= hi_next;
    pos      <= pos_next;
    probe_ok <= probe_ok_next;
    found_r  <= found_r_next;
    cnt_r    <= cnt_r_next;
    rej_r    <= rej_r_next;
    mv_left  <= mv_left_next;
    rd_ptr   <= rd_ptr_next;
    sh_valid <= sh_valid_next;
    sh_addr  <= sh_addr_next;
    shift_up <= shift_up_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      was_present      <= found_r;
      multiplicity     <= cnt_r;
      distinct_entries <= used;
      rejected         <= rej_r;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/smt_check.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smt_check
// Port-level checks for the sorted multiset table, bound to the top level.
// ----------------------------------------------------------------------------
module smt_check #(
  parameter int CAPACITY    = 2048,
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 16
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic                          was_present,
  input wire logic [COUNT_WIDTH-1:0]        multiplicity,
  input wire logic [$clog2(CAPACITY+1)-1:0] distinct_entries,
  input wire logic                          rejected
);
  localparam int CW = $clog2(CAPACITY + 1);

  // stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(multiplicity)
      && $stable(was_present) && $stable(distinct_entries) && $stable(rejected))
    else $error("stalled output item changed");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // rejected insert: saturated count or full table
  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |->
      (was_present && (&multiplicity)) ||
      (!was_present && multiplicity == '0 && distinct_entries == CW'(CAPACITY)))
    else $error("rejected item inconsistent");

  // an absent value ends with count zero, or one after an insert
  a_absent_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !was_present |-> multiplicity == '0 ||
      (multiplicity == COUNT_WIDTH'(1) && distinct_entries != '0))
    else $error("count of absent value wrong");

  a_distinct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> distinct_entries <= CW'(CAPACITY) &&
      (multiplicity == '0 || distinct_entries != '0))
    else $error("distinct entry count out of range");

endmodule

bind sorted_multiset_table smt_check #(
  .CAPACITY(CAPACITY),
  .VALUE_WIDTH(VALUE_WIDTH),
  .COUNT_WIDTH(COUNT_WIDTH)
) u_smt_check (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .was_present(was_present),
  .multiplicity(multiplicity),
  .distinct_entries(distinct_entries),
  .rejected(rejected)
);
`default_nettype wire

// ----- tb/sv/tb_sorted_multiset_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_multiset_table
// Self-checking bench for the sorted multiset table. A shadow copy of the
// ascending value/count table predicts every result, and each result leaving
// the block is checked field by field against the oldest prediction. Stimulus
// covers corner values and random operation mixes with idle and stall
// patterns on both sides.
// ----------------------------------------------------------------------------
module tb_sorted_multiset_table;
  import smt_pkg::*;

  localparam int CAPACITY     = 2048;
  localparam int VALUE_WIDTH  = 32;
  localparam int COUNT_WIDTH  = 16;
  localparam int DIST_WIDTH   = $clog2(CAPACITY + 1);
  localparam int POOL_SIZE    = 20;
  localparam int DRAIN_CYCLES = CAPACITY + 64;
  localparam int MAX_REPORTS  = 30;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  typedef struct packed {
    logic                   was_present;
    logic [COUNT_WIDTH-1:0] multiplicity;
    logic [DIST_WIDTH-1:0]  distinct_entries;
    logic                   rejected;
  } table_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [1:0] op = OP_QUERY;
  logic signed [VALUE_WIDTH-1:0] value = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic was_present;
  logic [COUNT_WIDTH-1:0] multiplicity;
  logic [DIST_WIDTH-1:0] distinct_entries;
  logic rejected;

  logic signed [VALUE_WIDTH-1:0] shadow_value [CAPACITY];
  logic [COUNT_WIDTH-1:0] shadow_count [CAPACITY];
  int shadow_used = 0;

  table_result_t pending_results [$];
  logic signed [VALUE_WIDTH-1:0] value_pool [POOL_SIZE];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int mismatches = 0;

  sorted_multiset_table #(
    .CAPACITY(CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .was_present(was_present),
    .multiplicity(multiplicity),
    .distinct_entries(distinct_entries),
    .rejected(rejected)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // lower-bound search, then the table update for one item
  function automatic table_result_t multiset_update(input logic [1:0] code,
                                                    input logic signed [VALUE_WIDTH-1:0] val);
    int lo;
    int hi;
    int mid;
    int pos;
    int i;
    logic found;
    logic [COUNT_WIDTH-1:0] cnt;
    table_result_t res;
    lo = 0;
    hi = shadow_used;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (shadow_value[mid] < val) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    pos = lo;
    found = (pos < shadow_used) && (shadow_value[pos] == val);
    cnt = found ? shadow_count[pos] : '0;
    res.rejected = 1'b0;
    if (code == OP_INSERT) begin
      if (found) begin
        if (cnt == COUNT_MAX) begin
          res.rejected = 1'b1;
        end else begin
          cnt++;
          shadow_count[pos] = cnt;
        end
      end else if (shadow_used >= CAPACITY) begin
        res.rejected = 1'b1;
      end else begin
        for (i = shadow_used; i > pos; i--) begin
          shadow_value[i] = shadow_value[i-1];
          shadow_count[i] = shadow_count[i-1];
        end
        shadow_value[pos] = val;
        shadow_count[pos] = COUNT_WIDTH'(1);
        cnt = COUNT_WIDTH'(1);
        shadow_used++;
      end
    end else if (code == OP_REMOVE && found) begin
      cnt--;
      if (cnt == 0) begin
        for (i = pos; i + 1 < shadow_used; i++) begin
          shadow_value[i] = shadow_value[i+1];
          shadow_count[i] = shadow_count[i+1];
        end
        shadow_used--;
      end else begin
        shadow_count[pos] = cnt;
      end
    end
    res.was_present = found;
    res.multiplicity = cnt;
    res.distinct_entries = DIST_WIDTH'(shadow_used);
    return res;
  endfunction

  task automatic put_item(input logic [1:0] code, input logic signed [VALUE_WIDTH-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results = {pending_results, multiset_update(code, val)};
    items_accepted++;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0d got %0d", $time, name, exp_v, act_v);
      end
    end
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: result with none expected, expected nothing got count %0d",
                   $time, multiplicity);
        end
      end else begin
        want = pending_results.pop_front();
        check_field("was_present", 32'(want.was_present), 32'(was_present));
        check_field("multiplicity", 32'(want.multiplicity), 32'(multiplicity));
        check_field("distinct_entries", 32'(want.distinct_entries),
                    32'(distinct_entries));
        check_field("rejected", 32'(want.rejected), 32'(rejected));
      end
      results_checked++;
    end
  end

  task automatic test_directed_corners();
    put_item(OP_QUERY, -5);
    put_item(OP_REMOVE, 7);
    put_item(OP_INSERT, VALUE_MIN);
    put_item(OP_INSERT, VALUE_MAX);
    put_item(OP_INSERT, 0);
    put_item(OP_INSERT, -1);
    put_item(OP_INSERT, 0);
    put_item(OP_INSERT, VALUE_MIN);
    put_item(OP_UNUSED, 0);
    put_item(OP_UNUSED, 5);
    put_item(OP_QUERY, VALUE_MAX);
    put_item(OP_INSERT, 1);
    put_item(OP_INSERT, -2);
    put_item(OP_REMOVE, 0);
    put_item(OP_REMOVE, 0);
    put_item(OP_REMOVE, 0);
    put_item(OP_REMOVE, VALUE_MIN);
    put_item(OP_REMOVE, VALUE_MIN);
    put_item(OP_REMOVE, VALUE_MAX);
    put_item(OP_QUERY, -1);
    put_item(OP_REMOVE, -1);
    put_item(OP_REMOVE, 1);
    put_item(OP_REMOVE, -2);
    put_item(OP_QUERY, VALUE_MIN);
  endtask

  task automatic test_random_mix(input int items, input int send_pct, input int recv_pct);
    int k;
    int pick;
    logic [1:0] code;
    logic signed [VALUE_WIDTH-1:0] val;
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    for (k = 0; k < items; k++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        code = OP_INSERT;
      end else if (pick < 75) begin
        code = OP_REMOVE;
      end else if (pick < 95) begin
        code = OP_QUERY;
      end else begin
        code = OP_UNUSED;
      end
      if ($urandom_range(4) == 0) begin
        val = $urandom;
      end else begin
        val = value_pool[$urandom_range(POOL_SIZE - 1)];
      end
      put_item(code, val);
    end
  endtask

  initial begin
    int k;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 8;
    stall_pct = 45;
    test_directed_corners();
    // small pool so random items keep hitting stored values
    value_pool[0] = VALUE_MIN;
    value_pool[1] = VALUE_MAX;
    value_pool[2] = 0;
    value_pool[3] = -1;
    value_pool[4] = 1;
    for (k = 5; k < POOL_SIZE; k++) begin
      value_pool[k] = $urandom;
    end
    test_random_mix(89, 8, 45);
    test_random_mix(89, 45, 8);
    test_random_mix(89, 0, 0);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d items: corner values and extreme signed values,",
             items_accepted);
    $display("then random mixes under three idle patterns; %0d results, %0d mismatches",
             results_checked, mismatches);
    if (mismatches == 0) begin
      $display("** sorted_multiset_table: PASSED **");
    end else begin
      $display("** sorted_multiset_table: FAILED **");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("timeout with %0d results still expected", pending_results.size());
    $display("** sorted_multiset_table: FAILED **");
    $finish;
  end

endmodule
